@@ rtl/dspm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dspm_pkg
// shared constants and types of the dot-star pattern matcher
// ----------------------------------------------------------------------------
package dspm_pkg;

  localparam int MAX_PATTERN = 32;

  localparam logic [7:0] CH_ANY  = 8'd46;
  localparam logic [7:0] CH_STAR = 8'd42;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_APPEND  = 2'd1,
    OP_SUBJECT = 2'd2,
    OP_RESTART = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WAVE = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  // row update travelling from one cell to the next
  typedef struct packed {
    logic       valid;
    logic       first;  // receiving cell is pattern position one
    logic       oc;     // old row bit of the left neighbor
    logic       n1;     // new row bit of the left neighbor
    logic       n2;     // new row bit two positions to the left
    logic [7:0] pp;     // pattern char of the left neighbor
  } wave_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic       clear;
    logic       append;
    logic       reload;
    logic [7:0] ch;
    logic [7:0] subj;
  } ctl_t;

  // what a cell reports to the controller
  typedef struct packed {
    logic hit;
    logic match;
  } tap_t;

endpackage

@@ rtl/dspm_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dspm_cell
// one pattern position: char, empty-subject bit, row bit and wave stage
// ----------------------------------------------------------------------------
module dspm_cell
  import dspm_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  ctl_t  ctl,
  input  wave_t wave_in,
  input  logic  left_filled,
  input  logic  right_filled,
  input  logic  e_m2,
  output wave_t wave_out,
  output logic  filled,
  output logic  e_bit,
  output tap_t  tap
);

  logic [7:0] p_r;
  logic       e_r;
  logic       c_r;
  logic       filled_r;
  wave_t      wave_r;

  logic       wr_en;
  logic       e_new;
  logic       n_new;
  logic       last;
  logic       prev_hit;
  wave_t      wave_nxt;

  assign wr_en = ctl.append && !filled_r && left_filled;
  assign e_new = (ctl.ch == CH_STAR) ? e_m2 : 1'b0;
  assign last  = filled_r && !right_filled;
  assign prev_hit = (ctl.subj == wave_in.pp) || (wave_in.pp == CH_ANY);

  always_comb begin
    if ((ctl.subj == p_r) || (p_r == CH_ANY)) begin
      n_new = wave_in.oc;
    end else if ((p_r == CH_STAR) && !wave_in.first) begin
      n_new = wave_in.n2 || (prev_hit && c_r);
    end else begin
      n_new = 1'b0;
    end
  end

  always_comb begin
    wave_nxt.valid = wave_in.valid && !ctl.clear && !ctl.reload;
    wave_nxt.first = 1'b0;
    wave_nxt.oc    = c_r;
    wave_nxt.n1    = n_new;
    wave_nxt.n2    = wave_in.n1;
    wave_nxt.pp    = p_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filled_r     <= 1'b0;
      wave_r.valid <= 1'b0;
    end else begin
      if (ctl.clear) begin
        filled_r <= 1'b0;
      end else if (wr_en) begin
        filled_r <= 1'b1;
      end
      wave_r <= wave_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      p_r <= ctl.ch;
      e_r <= e_new;
    end
    if (ctl.reload) begin
      c_r <= wr_en ? e_new : e_r;
    end else if (wave_in.valid && !ctl.clear) begin
      c_r <= n_new;
    end
  end

  assign wave_out  = wave_r;
  assign filled    = filled_r;
  assign e_bit     = e_r;
  assign tap.hit   = wave_in.valid && last;
  assign tap.match = last && c_r;

endmodule

@@ rtl/dspm_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dspm_ctrl
// request decode, row position zero, wave launch and result register
// ----------------------------------------------------------------------------
module dspm_ctrl
  import dspm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic [1:0] in_tuser,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,
  input  logic       full,
  input  logic       nonempty,
  input  logic       any_hit,
  input  logic       any_match,
  output ctl_t       ctl,
  output wave_t      wave0
);

  state_t     state_r, state_nxt;
  logic       c0_r, c0_nxt;
  logic       status_r, status_nxt;
  logic [7:0] subj_r, subj_nxt;
  wave_t      wave0_r, wave0_nxt;
  logic       out_valid_r;
  logic       out_matched_r;
  logic       out_status_r;
  logic       accept;
  logic       out_free;
  opcode_t    op;

  assign op        = opcode_t'(in_tuser);
  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  always_comb begin
    state_nxt   = state_r;
    c0_nxt      = c0_r;
    status_nxt  = status_r;
    subj_nxt    = subj_r;
    wave0_nxt   = '0;
    ctl.clear   = 1'b0;
    ctl.append  = 1'b0;
    ctl.reload  = 1'b0;
    ctl.ch      = in_tdata;
    ctl.subj    = subj_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          status_nxt = 1'b0;
          state_nxt  = ST_FIN;
          unique case (op)
            OP_CLEAR: begin
              ctl.clear = 1'b1;
              c0_nxt    = 1'b1;
            end
            OP_APPEND: begin
              if (full) begin
                status_nxt = 1'b1;
              end else begin
                ctl.append = 1'b1;
                ctl.reload = 1'b1;
                c0_nxt     = 1'b1;
              end
            end
            OP_SUBJECT: begin
              c0_nxt   = 1'b0;
              subj_nxt = in_tdata;
              if (nonempty) begin
                wave0_nxt.valid = 1'b1;
                wave0_nxt.first = 1'b1;
                wave0_nxt.oc    = c0_r;
                state_nxt       = ST_WAVE;
              end
            end
            OP_RESTART: begin
              ctl.reload = 1'b1;
              c0_nxt     = 1'b1;
            end
            default: begin
              state_nxt = ST_FIN;
            end
          endcase
        end
      end
      ST_WAVE: begin
        if (any_hit) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      c0_r          <= 1'b1;
      wave0_r.valid <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      c0_r    <= c0_nxt;
      wave0_r <= wave0_nxt;
      if ((state_r == ST_FIN) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    subj_r   <= subj_nxt;
    if ((state_r == ST_FIN) && out_free) begin
      out_matched_r <= nonempty ? any_match : c0_r;
      out_status_r  <= status_r;
    end
  end

  assign wave0      = wave0_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_status_r, out_matched_r};

endmodule

@@ rtl/dot_star_pattern_matcher_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dot_star_pattern_matcher_unit
// whole-string matcher for patterns with '.' and '*', one cell per position
// ----------------------------------------------------------------------------
// input requests: in_tuser carries the opcode (clear, append pattern char,
// subject char, restart), in_tdata the char. every request gives one result
// on out_tdata: bit 0 matched, bit 1 status (append refused, store full).
// clear, append and restart go from accept to the finish state and then to
// the output register. a subject char with a non-empty pattern first sends
// its row update down the chain of cells, one pattern position per cycle,
// and the result is taken once it reaches the last filled cell; with an
// empty pattern it goes straight to the finish state.
// one request is in work at a time; the next is accepted as soon as the
// result sits in the output register, even if the receiver has not taken it.
// a stalled receiver holds the result; a following request finishes its
// work and then waits until the output register is free.
// reset empties the pattern and the subject at once, no clearing pass.
// ----------------------------------------------------------------------------
module dot_star_pattern_matcher_unit
  import dspm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // char_code
  input  logic [1:0] in_tuser,   // opcode
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // matched, status, zero fill
);

  ctl_t  ctl;
  wave_t wave [0:MAX_PATTERN];
  logic  filled [0:MAX_PATTERN+1];
  logic  e_row [0:MAX_PATTERN];
  logic  e_m2 [1:MAX_PATTERN];
  logic  [MAX_PATTERN-1:0] hit_vec;
  logic  [MAX_PATTERN-1:0] match_vec;

  assign filled[0]             = 1'b1;
  assign filled[MAX_PATTERN+1] = 1'b0;
  assign e_row[0]              = 1'b1;

  dspm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .full       (filled[MAX_PATTERN]),
    .nonempty   (filled[1]),
    .any_hit    (|hit_vec),
    .any_match  (|match_vec),
    .ctl        (ctl),
    .wave0      (wave[0])
  );

  for (genvar k = 1; k <= MAX_PATTERN; k++) begin : g_cell
    tap_t tap;

    if (k == 1) begin : g_first
      assign e_m2[k] = 1'b0;
    end else begin : g_rest
      assign e_m2[k] = e_row[k-2];
    end

    dspm_cell u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctl          (ctl),
      .wave_in      (wave[k-1]),
      .left_filled  (filled[k-1]),
      .right_filled (filled[k+1]),
      .e_m2         (e_m2[k]),
      .wave_out     (wave[k]),
      .filled       (filled[k]),
      .e_bit        (e_row[k]),
      .tap          (tap)
    );

    assign hit_vec[k-1]   = tap.hit;
    assign match_vec[k-1] = tap.match;
  end

endmodule

@@ rtl/dspm_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dspm_checker
// port-level checks of the pattern matcher, bound to the top level
// ----------------------------------------------------------------------------
module dspm_checker
  import dspm_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  // result held while the receiver stalls
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // fill bits of a result stay zero
  a_out_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[7:2] == 6'd0))
    else $error("result fill bits set");

  // one request in work at a time
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while busy");

  // no result right after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind dot_star_pattern_matcher_unit dspm_checker u_dspm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
